// ----- design/led_fade_and_dither_pwm_defines.svh -----
// ----------------------------------------------------------------------------
// LED fade and dither PWM assertion macros
// Shared concurrent assertion forms for the checker of the LED engine.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_AND_DITHER_PWM_DEFINES_SVH
`define LED_FADE_AND_DITHER_PWM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFDP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("LED engine check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define LFDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LED engine check failed in the next cycle");

`endif

// ----- design/lfdp_pkg.sv -----
// ----------------------------------------------------------------------------
// LED fade and dither PWM package
// Types, constants and codes shared by the LED engine modules.
// ----------------------------------------------------------------------------
package lfdp_pkg;

   localparam int NUM_LEDS_DEF  = 64;
   localparam int MAX_LEVEL_DEF = 255;
   localparam int WORD_BITS     = 32;

   localparam logic OP_FADE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [5:0]  led_index;
      logic [7:0]  target_level;
      logic [15:0] fade_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]  word_index;
      logic [31:0] lit_bits;
      logic [31:0] finished_bits;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         level;
      logic signed [8:0]  delta;
      logic [15:0]        length;
      logic [15:0]        remaining;
      logic signed [16:0] acc;
   } fade_entry_type;

   localparam int FADE_ENTRY_W = $bits(fade_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_START_WR,
      ST_FADE_RD,
      ST_FADE_CHK,
      ST_FADE_DIV,
      ST_FADE_WR,
      ST_DITH_RD,
      ST_DITH_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic start_rd;
      logic start_wr;
      logic idx_clr;
      logic idx_inc;
      logic fade_rd;
      logic div_start;
      logic div_step;
      logic fade_wr;
      logic pos_load;
      logic dith_rd;
      logic dith_wr;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic led_ok;
      logic remaining_nz;
      logic div_last;
      logic idx_last;
   } status_type;

endpackage

// ----- design/lfdp_ram.sv -----
// ----------------------------------------------------------------------------
// LED engine generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lfdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// LED engine controller
// Sequences fade start, the fade pass with its divider and the dither pass.
// ----------------------------------------------------------------------------
module lfdp_ctrl import lfdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tick) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_FADE_RD;
            end else if (status.led_ok) begin
               cmd.start_rd = 1'b1;
               state_in     = ST_START_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START_WR: begin
            cmd.start_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_FADE_RD: begin
            cmd.fade_rd = 1'b1;
            state_in    = ST_FADE_CHK;
         end
         ST_FADE_CHK: begin
            if (status.remaining_nz) begin
               cmd.div_start = 1'b1;
               state_in      = ST_FADE_DIV;
            end else begin
               state_in = ST_FADE_WR;
            end
         end
         ST_FADE_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FADE_WR;
            end
         end
         ST_FADE_WR: begin
            cmd.fade_wr = 1'b1;
            if (status.idx_last) begin
               cmd.idx_clr  = 1'b1;
               cmd.pos_load = 1'b1;
               state_in     = ST_DITH_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_FADE_RD;
            end
         end
         ST_DITH_RD: begin
            cmd.dith_rd = 1'b1;
            state_in    = ST_DITH_WR;
         end
         ST_DITH_WR: begin
            cmd.dith_wr = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_DITH_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/lfdp_datapath.sv -----
// ----------------------------------------------------------------------------
// LED engine datapath
// Per-LED fade and dither stores, the serial divider and the word assembly.
// ----------------------------------------------------------------------------
module lfdp_datapath import lfdp_pkg::*; #(
   parameter int NUM_LEDS  = NUM_LEDS_DEF,
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int LEVEL_TOP = (MAX_LEVEL < 255) ? MAX_LEVEL : 255;

   req_type                  item_ff;
   logic [5:0]               offset_ff;
   logic [LED_W-1:0]         idx_ff;
   logic [8:0]               pos_ff;
   logic [4:0]               bit_ff;
   logic [2:0]               grp_ff;
   logic [WORD_BITS-1:0]     lit_ff, fin_ff;
   logic                     rsp_strobe_ff;
   rsp_type                  rsp_ff;
   logic [NUM_LEDS-1:0]      fade_vld_ff, pwm_vld_ff;
   logic                     fade_rv_ff, pwm_rv_ff;
   logic [16:0]              quo_ff;
   logic [15:0]              rem_ff;
   logic [4:0]               cnt_ff;
   logic                     neg_ff;

   logic [8:0]               led_x, pos_sel;
   logic [LED_W-1:0]         led_addr, pos_addr, fade_rd_addr, fade_wr_addr;
   logic                     fade_rd_en, fade_wr_en;
   logic [FADE_ENTRY_W-1:0]  fade_rd_data, fade_wr_data;
   logic [7:0]               pwm_rd_data, pwm_wr_data;
   logic                     fin_rd_data, fin_wr_data;
   fade_entry_type           entry, adv_entry, st_entry;
   logic signed [17:0]       sum;
   logic [17:0]              mag;
   logic [16:0]              shifted;
   logic                     ge;
   logic                     r_nz;
   logic [17:0]              k18, lv18, lsum;
   logic [7:0]               pwm_acc;
   logic [12:0]              dsum;
   logic                     lit_on, grp_end;
   logic [WORD_BITS-1:0]     lit_next, fin_next;

   assign led_x    = 9'(item_ff.led_index);
   assign led_addr = led_x[LED_W-1:0];
   assign pos_sel  = (pos_ff >= 9'(NUM_LEDS)) ? 9'd0 : pos_ff;
   assign pos_addr = pos_sel[LED_W-1:0];

   assign fade_rd_en   = cmd.start_rd | cmd.fade_rd | cmd.dith_rd;
   assign fade_rd_addr = cmd.start_rd ? led_addr : (cmd.dith_rd ? pos_addr : idx_ff);
   assign fade_wr_en   = cmd.start_wr | cmd.fade_wr;
   assign fade_wr_addr = cmd.start_wr ? led_addr : idx_ff;
   assign fade_wr_data = cmd.start_wr ? st_entry : adv_entry;

   assign entry   = fade_rv_ff ? fade_entry_type'(fade_rd_data) : '0;
   assign pwm_acc = pwm_rv_ff ? pwm_rd_data : 8'd0;

   // Fade start keeps the level and the accumulator of the LED.
   always_comb begin
      st_entry           = entry;
      st_entry.length    = item_ff.fade_ticks;
      st_entry.remaining = item_ff.fade_ticks;
      st_entry.delta     = $signed({1'b0, item_ff.target_level}) - $signed({1'b0, entry.level});
   end

   assign sum     = 18'(entry.acc) + 18'(entry.delta);
   assign mag     = sum[17] ? 18'(-sum) : 18'(sum);
   assign shifted = {rem_ff, quo_ff[16]};
   assign ge      = shifted >= {1'b0, entry.length};

   // Negative sums round the quotient up, positive ones down.
   always_comb begin
      r_nz      = rem_ff != 16'd0;
      k18       = 18'(quo_ff) + ((neg_ff && r_nz) ? 18'd1 : 18'd0);
      lv18      = 18'(entry.level);
      lsum      = lv18 + k18;
      adv_entry = entry;
      fin_wr_data = 1'b0;
      if (entry.remaining != 16'd0) begin
         adv_entry.remaining = entry.remaining - 16'd1;
         fin_wr_data = entry.remaining == 16'd1;
         if (neg_ff) begin
            adv_entry.level = (k18 > lv18) ? 8'd0 : 8'(lv18 - k18);
            adv_entry.acc   = r_nz ? $signed(17'({1'b0, entry.length} - {1'b0, rem_ff}))
                                   : 17'sd0;
         end else begin
            adv_entry.level = (lsum > 18'(LEVEL_TOP)) ? 8'(LEVEL_TOP) : 8'(lsum);
            adv_entry.acc   = $signed(17'(rem_ff));
         end
      end
   end

   assign dsum        = 13'(pwm_acc) + 13'(entry.level);
   assign lit_on      = dsum >= 13'(MAX_LEVEL);
   assign pwm_wr_data = lit_on ? 8'(dsum - 13'(MAX_LEVEL)) : dsum[7:0];
   assign lit_next    = {lit_ff[WORD_BITS-2:0], lit_on};
   assign fin_next    = {fin_ff[WORD_BITS-2:0], fin_rd_data};
   assign grp_end     = (bit_ff == 5'd31) || status.idx_last;

   assign status.is_tick      = item_ff.operation == OP_TICK;
   assign status.led_ok       = 9'(item_ff.led_index) < 9'(NUM_LEDS);
   assign status.remaining_nz = entry.remaining != 16'd0;
   assign status.div_last     = cnt_ff == 5'd1;
   assign status.idx_last     = idx_ff == LED_W'(NUM_LEDS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= 6'd0;
         idx_ff        <= '0;
         cnt_ff        <= 5'd0;
         rsp_strobe_ff <= 1'b0;
         fade_vld_ff   <= '0;
         pwm_vld_ff    <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.div_start) begin
            cnt_ff <= 5'd17;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - 5'd1;
         end
         if (fade_wr_en) begin
            fade_vld_ff[fade_wr_addr] <= 1'b1;
         end
         if (cmd.dith_wr) begin
            pwm_vld_ff[idx_ff] <= 1'b1;
            rsp_strobe_ff      <= grp_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (fade_rd_en) begin
         fade_rv_ff <= fade_vld_ff[fade_rd_addr];
      end
      if (cmd.dith_rd) begin
         pwm_rv_ff <= pwm_vld_ff[idx_ff];
      end
      if (cmd.div_start) begin
         quo_ff <= mag[16:0];
         rem_ff <= 16'd0;
         neg_ff <= sum[17];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[15:0], ge};
         rem_ff <= ge ? 16'(shifted - {1'b0, entry.length}) : shifted[15:0];
      end
      if (cmd.pos_load) begin
         pos_ff <= 9'(offset_ff);
         bit_ff <= 5'd0;
         grp_ff <= 3'd0;
         lit_ff <= '0;
         fin_ff <= '0;
      end else if (cmd.dith_wr) begin
         pos_ff <= pos_sel + 9'd1;
         bit_ff <= bit_ff + 5'd1;
         lit_ff <= grp_end ? '0 : lit_next;
         fin_ff <= grp_end ? '0 : fin_next;
         if (grp_end) begin
            grp_ff                 <= grp_ff + 3'd1;
            rsp_ff.word_index      <= grp_ff;
            rsp_ff.lit_bits        <= lit_next;
            rsp_ff.finished_bits   <= fin_next;
            rsp_ff.last_word       <= status.idx_last;
         end
      end
   end

   lfdp_ram #(.WIDTH(FADE_ENTRY_W), .DEPTH(NUM_LEDS)) u_fade_ram (
      .clock   (clock),
      .wr_en   (fade_wr_en),
      .wr_addr (fade_wr_addr),
      .wr_data (fade_wr_data),
      .rd_en   (fade_rd_en),
      .rd_addr (fade_rd_addr),
      .rd_data (fade_rd_data)
   );

   lfdp_ram #(.WIDTH(8), .DEPTH(NUM_LEDS)) u_pwm_ram (
      .clock   (clock),
      .wr_en   (cmd.dith_wr),
      .wr_addr (idx_ff),
      .wr_data (pwm_wr_data),
      .rd_en   (cmd.dith_rd),
      .rd_addr (idx_ff),
      .rd_data (pwm_rd_data)
   );

   lfdp_ram #(.WIDTH(1), .DEPTH(NUM_LEDS)) u_fin_ram (
      .clock   (clock),
      .wr_en   (cmd.fade_wr),
      .wr_addr (idx_ff),
      .wr_data (fin_wr_data),
      .rd_en   (cmd.dith_rd),
      .rd_addr (idx_ff),
      .rd_data (fin_rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/led_fade_and_dither_pwm.sv -----
// ----------------------------------------------------------------------------
// LED fade and dither PWM engine
// Linear per-LED fades with saturating levels and first-order sigma-delta
// dithering into 32-bit on/off words.
//
//   Channel  Ports                          Handshake
//   input    start, busy, req_data          taken when start and not busy
//   result   rsp_strobe, rsp_data           one cycle per beat, no stall
//   config   csr_wr_en, csr_wr_data         written when csr_wr_en is high
//
// A fade start reads the fade entry of the LED and writes it back. A tick is
// decoded, then the fade pass reads, checks and writes each LED, running the
// divider for each LED that is fading, and the dither pass reads and writes
// each LED for one output bit. The one-bit-per-cycle divider and the single
// read port of the fade store set the pass lengths. Reset clears the fade and
// dither stores at once through valid bits. Result beats cannot be stalled.
// ----------------------------------------------------------------------------
module led_fade_and_dither_pwm import lfdp_pkg::*; #(
   parameter int NUM_LEDS  = NUM_LEDS_DEF,
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   lfdp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   lfdp_datapath #(.NUM_LEDS(NUM_LEDS), .MAX_LEVEL(MAX_LEVEL)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- design/lfdp_checker.sv -----
// ----------------------------------------------------------------------------
// LED engine port checker
// Watches the top-level ports for ordering of beats against busy.
// ----------------------------------------------------------------------------
`include "led_fade_and_dither_pwm_defines.svh"

module lfdp_checker import lfdp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   `LFDP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `LFDP_ASSERT_NEXT(a_beat_spaced, clock, reset, rsp_strobe, !rsp_strobe)
   `LFDP_ASSERT_SAME(a_last_idle, clock, reset, rsp_strobe && rsp_data.last_word, !busy)
   `LFDP_ASSERT_SAME(a_mid_busy, clock, reset, rsp_strobe && !rsp_data.last_word, busy)

endmodule

bind led_fade_and_dither_pwm lfdp_checker u_lfdp_checker (.*);

// ----- tb/tb_led_fade_and_dither_pwm.sv -----
// ----------------------------------------------------------------------------
// LED fade and dither PWM testbench
// Drives fade starts and refresh ticks through the command port, keeps its
// own model of the fade and dither stores, and checks every result beat.
// ----------------------------------------------------------------------------
module tb_led_fade_and_dither_pwm;
   import lfdp_pkg::*;

   localparam int LEDS      = 64;
   localparam int TOP_LEVEL = 255;
   localparam int WORDS     = 2;
   localparam int STALL_MAX = 20000;

   typedef struct {
      req_type     item;
      bit          known;
      logic [31:0] lit0;
      logic [31:0] fin0;
   } row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [5:0] csr_wr_data;

   led_fade_and_dither_pwm dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   int      errors;
   int      stall_cycles;
   bit      quiet;
   rsp_type words_due[$];
   int      offset_model;
   int      lvl[LEDS];
   int      dith_acc[LEDS];
   int      delta[LEDS];
   int      len[LEDS];
   int      remain[LEDS];
   int      facc[LEDS];
   row_type rows[$];
   int      next_known;
   logic [31:0] known_lit0[$];
   logic [31:0] known_fin0[$];

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void step_fade(int j);
      longint acc;
      longint k;
      int     lv;
      acc = facc[j] + delta[j];
      lv  = lvl[j];
      if (len[j] != 0) begin
         if (acc < 0) begin
            k   = (-acc + len[j] - 1) / len[j];
            acc = acc + k * len[j];
            lv  = (k > lv) ? 0 : lv - int'(k);
         end else if (acc >= len[j]) begin
            k   = acc / len[j];
            acc = acc - k * len[j];
            lv  = (k > TOP_LEVEL) ? TOP_LEVEL : lv + int'(k);
            if (lv > TOP_LEVEL) lv = TOP_LEVEL;
         end
      end
      facc[j] = int'(acc);
      lvl[j]  = lv;
   endfunction

   function automatic void predict_beat(req_type it);
      logic [31:0] lit[WORDS];
      logic [31:0] fin[WORDS];
      int          pos;
      int          acc;
      rsp_type     w;
      if (it.operation == OP_FADE) begin
         len[it.led_index]    = int'(it.fade_ticks);
         remain[it.led_index] = int'(it.fade_ticks);
         delta[it.led_index]  = int'(it.target_level) - lvl[it.led_index];
         return;
      end
      for (int g = 0; g < WORDS; g++) begin
         lit[g] = '0;
         fin[g] = '0;
      end
      for (int i = 0; i < LEDS; i++) begin
         if (remain[i] != 0) begin
            step_fade(i);
            remain[i]--;
            if (remain[i] == 0) fin[i / 32][31 - i % 32] = 1'b1;
         end
      end
      pos = offset_model;
      for (int i = 0; i < LEDS; i++) begin
         if (pos >= LEDS) pos = 0;
         acc = dith_acc[i] + lvl[pos];
         if (acc >= TOP_LEVEL) begin
            acc -= TOP_LEVEL;
            lit[i / 32][31 - i % 32] = 1'b1;
         end
         dith_acc[i] = acc & 8'hFF;
         pos++;
      end
      for (int g = 0; g < WORDS; g++) begin
         w.word_index    = 3'(g);
         w.lit_bits      = lit[g];
         w.finished_bits = fin[g];
         w.last_word     = (g == WORDS - 1);
         words_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) predict_beat(req_data);
         if (rsp_strobe) begin
            if (words_due.size() == 0) begin
               $error("unexpected result beat: word_index %0d", rsp_data.word_index);
               errors++;
            end else begin
               want = words_due.pop_front();
               if (want.word_index == 0 && known_lit0.size() > 0 &&
                   next_known > 0) begin
                  want.lit_bits      = known_lit0.pop_front();
                  want.finished_bits = known_fin0.pop_front();
                  next_known--;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index expected %0d actual %0d",
                         want.word_index, rsp_data.word_index);
                  errors++;
               end
               if (rsp_data.lit_bits !== want.lit_bits) begin
                  $error("lit_bits expected %h actual %h",
                         want.lit_bits, rsp_data.lit_bits);
                  errors++;
               end
               if (rsp_data.finished_bits !== want.finished_bits) begin
                  $error("finished_bits expected %h actual %h",
                         want.finished_bits, rsp_data.finished_bits);
                  errors++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word expected %0d actual %0d",
                         want.last_word, rsp_data.last_word);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_MAX) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_beat(req_type it);
      if (!quiet && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (words_due.size() != 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_offset(logic [5:0] value);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      offset_model = int'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type make_row(logic op, int led, int tgt, int ticks);
      req_type r;
      r.operation    = op;
      r.led_index    = 6'(led);
      r.target_level = 8'(tgt);
      r.fade_ticks   = 16'(ticks);
      return r;
   endfunction

   function automatic void add_row(req_type it, bit known, logic [31:0] lit0,
                                   logic [31:0] fin0);
      row_type r;
      r.item  = it;
      r.known = known;
      r.lit0  = lit0;
      r.fin0  = fin0;
      rows.push_back(r);
   endfunction

   function automatic req_type random_beat();
      req_type r;
      int      sel;
      r   = req_type'($bits(req_type)'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         r.operation = OP_TICK;
      end else begin
         r.operation = OP_FADE;
         if (sel < 85) r.fade_ticks = 16'($urandom_range(0, 24));
         else if (sel < 93) r.fade_ticks = 16'($urandom_range(25, 600));
         if ($urandom_range(0, 9) == 0) r.target_level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return r;
   endfunction

   initial begin
      logic [5:0] offsets[5];
      errors     = 0;
      quiet      = 1'b0;
      next_known = 0;
      start      = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_wr_data = '0;
      offset_model = 0;
      for (int i = 0; i < LEDS; i++) begin
         lvl[i] = 0; dith_acc[i] = 0; delta[i] = 0;
         len[i] = 0; remain[i] = 0; facc[i] = 0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(make_row(OP_TICK, 0, 0, 0), 1'b1, 32'h0, 32'h0);
      add_row(make_row(OP_FADE, 0, 255, 1), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b1, 32'h8000_0000, 32'h8000_0000);
      add_row(make_row(OP_FADE, 63, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 63, 255, 3), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 5, 255, 65535), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 9, 200, 32768), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 63, 255, 65535), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 0, 0, 2), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 31, 17, 7), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 32, 255, 1), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 0, 255, 1), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);
      add_row(make_row(OP_FADE, 32, 0, 65535), 1'b0, '0, '0);
      add_row(make_row(OP_TICK, 0, 0, 0), 1'b0, '0, '0);

      foreach (rows[n]) begin
         if (rows[n].known) begin
            known_lit0.push_back(rows[n].lit0);
            known_fin0.push_back(rows[n].fin0);
            next_known++;
            drain();
         end
         send_beat(rows[n].item);
      end
      drain();

      offsets = '{6'd63, 6'd1, 6'd32, 6'($urandom_range(2, 62)), 6'd0};
      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         quiet = (p == 2);
         for (int n = 0; n < 82; n++) send_beat(random_beat());
         drain();
      end

      start <= 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
